// ===== rtl/tiled_masked_minimum_finder_core_defines.svh =====
// assertion macros shared by the checker
`ifndef TILED_MASKED_MINIMUM_FINDER_CORE_DEFINES_SVH
`define TILED_MASKED_MINIMUM_FINDER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TMMF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmmf: implication check failed");

// next-cycle implication, sampled on clk, off during reset
`define TMMF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmmf: next-cycle check failed");

`endif

// ===== rtl/tmmf_pkg.sv =====
package tmmf_pkg;

    localparam int MAX_COLS         = 8192;
    localparam int MAX_TILE_COLUMNS = 64;

    localparam int ELEV_W     = 32;
    localparam int ROW_W      = 16;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int SIZE_W     = 14;
    localparam int TILE_COL_W = (MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1;
    localparam int NTX_W      = $clog2(MAX_TILE_COLUMNS + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int DIV_W     = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_NODATA      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_ELEV_CEIL   = CFG_IDX_W'(4);

    localparam logic [ROW_W-1:0]  RESET_IMAGE_ROWS = ROW_W'(1024);
    localparam logic [SIZE_W-1:0] RESET_IMAGE_COLS = SIZE_W'(1024);
    localparam logic [SIZE_W-1:0] RESET_TILE_SIZE  = SIZE_W'(181);
    localparam logic [ELEV_W-1:0] RESET_NODATA     = 32'hFF80_0000;
    localparam logic [ELEV_W-1:0] RESET_ELEV_CEIL  = ELEV_W'(2559744);

    typedef struct packed {
        logic signed [ELEV_W-1:0] elevation;
        logic                     pixel_valid;
        logic                     first_pixel;
    } pixel_in_t;

    typedef struct packed {
        logic [ROW_W-1:0] anchor_row;
        logic [COL_W-1:0] anchor_col;
    } anchor_out_t;

    typedef struct packed {
        logic signed [ELEV_W-1:0] elevation;
        logic                     pixel_valid;
        logic                     tile_first;
        logic                     tile_last;
        logic [TILE_COL_W-1:0]    tile_col;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
    } tile_op_t;

    typedef struct packed {
        logic signed [ELEV_W-1:0] min_elev;
        logic [ROW_W-1:0]         min_row;
        logic [COL_W-1:0]         min_col;
        logic                     found;
    } tile_rec_t;

    localparam int REC_W = $bits(tile_rec_t);

    typedef struct packed {
        logic signed [ELEV_W-1:0] nodata;
        logic signed [ELEV_W-1:0] ceiling;
    } thresholds_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [SIZE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [SIZE_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef enum logic [2:0] {
        CALC_IDLE,
        CALC_COLS,
        CALC_ROWS,
        CALC_CPOS,
        CALC_RPOS
    } calc_state_t;

endpackage

// ===== rtl/tiled_masked_minimum_finder_core.sv =====
// channel   direction  handshake          payload
// in        input      in_valid/in_stall  pixel_in_t   (elevation, pixel_valid, first_pixel)
// out       output     out_valid/out_stall anchor_out_t (anchor_row, anchor_col)
// cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// one pixel per cycle while in_stall is low; a result passes queue, back stage, out register
// the front tracks the raster position with counters, the back does one read-modify-write
// of the tile record ram per pixel, with a 4-entry queue between the two
// after reset and after a write to image_rows, image_cols or the tile side the grid is
// recomputed by a shared 16-step divider: four divisions, with in_stall high
// and cfg_ready low throughout
// out_stall holds the output register; the queue absorbs the back's stall before in_stall rises
module tiled_masked_minimum_finder_core
    import tmmf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pixel_in_t             in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output anchor_out_t           out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    div_req_t      div_req;
    div_rsp_t      div_rsp;
    logic          op_push;
    tile_op_t      op_data;
    logic          q_pop;
    tile_op_t      q_head;
    queue_status_t q_status;
    thresholds_t   thresholds;

    tmmf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .op_push    (op_push),
        .op_data    (op_data),
        .q_status   (q_status),
        .thresholds (thresholds)
    );

    tmmf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tmmf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (op_push),
        .push_data (op_data),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    tmmf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .thresholds (thresholds),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

// ===== rtl/tmmf_ram.sv =====
module tmmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tmmf_div.sv =====
module tmmf_div
    import tmmf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quot_reg, quot_next;
    logic [SIZE_W-1:0]    rem_reg, rem_next;
    logic [SIZE_W-1:0]    divisor_reg, divisor_next;

    logic [SIZE_W:0] trial;
    logic [SIZE_W:0] diff;
    logic            fits;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quot_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (!busy_reg && req.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = DIV_CNT_W'(DIV_W);
            quot_next    = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[DIV_W-2:0], fits};
            rem_next  = fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== rtl/tmmf_front.sv =====
module tmmf_front
    import tmmf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pixel_in_t             in_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output div_req_t              div_req,
    input  div_rsp_t              div_rsp,
    output logic                  op_push,
    output tile_op_t              op_data,
    input  queue_status_t         q_status,
    output thresholds_t           thresholds
);

    // configuration
    logic [ROW_W-1:0]  image_rows_reg, image_rows_next;
    logic [SIZE_W-1:0] image_cols_reg, image_cols_next;
    logic [SIZE_W-1:0] tile_side_reg, tile_side_next;
    logic [ELEV_W-1:0] nodata_reg, nodata_next;
    logic [ELEV_W-1:0] ceiling_reg, ceiling_next;

    // tile grid
    logic [NTX_W-1:0] ntx_reg, ntx_next;
    logic [ROW_W-1:0] nty_reg, nty_next;
    logic [COL_W-1:0] offx_reg, offx_next;
    logic [COL_W-1:0] offy_reg, offy_next;

    // raster position of the next pixel and where it sits in the grid
    logic [COL_W-1:0] col_reg, col_next;
    logic             col_in_reg, col_in_next;
    logic [COL_W-1:0] tx_reg, tx_next;
    logic [COL_W-1:0] lx_reg, lx_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             row_in_reg, row_in_next;
    logic [ROW_W-1:0] ty_reg, ty_next;
    logic [COL_W-1:0] ly_reg, ly_next;

    calc_state_t calc_state_reg, calc_state_next;
    logic        launched_reg, launched_next;

    logic              accept;
    logic              cfg_we;
    logic              geom_write;
    logic [SIZE_W-1:0] cols_eff;
    logic [ROW_W-1:0]  rows_eff;
    logic [SIZE_W-1:0] ts_m1;
    logic              ts_nz;

    logic [COL_W-1:0]  cur_col;
    logic              cur_col_in;
    logic [COL_W-1:0]  cur_tx;
    logic [COL_W-1:0]  cur_lx;
    logic [ROW_W-1:0]  cur_row;
    logic              cur_row_in;
    logic [ROW_W-1:0]  cur_ty;
    logic [COL_W-1:0]  cur_ly;
    logic              lx_last;
    logic              ly_last;
    logic              in_grid;
    logic [COL_W:0]    col_p1;
    logic [ROW_W:0]    row_p1;
    logic              col_ge;
    logic              row_ge;

    assign cfg_ready = (calc_state_reg == CALC_IDLE);
    assign in_stall  = (calc_state_reg != CALC_IDLE) || q_status.full;
    assign accept    = in_valid && !in_stall;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign geom_write = cfg_we &&
                        (cfg_index inside {REG_IMAGE_ROWS, REG_IMAGE_COLS, REG_TILE_SIZE});

    always_comb
    begin
        image_rows_next = image_rows_reg;
        image_cols_next = image_cols_reg;
        tile_side_next  = tile_side_reg;
        nodata_next     = nodata_reg;
        ceiling_next    = ceiling_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_ROWS: image_rows_next = cfg_data[ROW_W-1:0];
                REG_IMAGE_COLS: image_cols_next = cfg_data[SIZE_W-1:0];
                REG_TILE_SIZE:  tile_side_next  = cfg_data[SIZE_W-1:0];
                REG_NODATA:     nodata_next     = cfg_data[ELEV_W-1:0];
                REG_ELEV_CEIL:  ceiling_next    = cfg_data[ELEV_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cols_eff = (image_cols_reg == '0) ? SIZE_W'(1) :
                      (image_cols_reg > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) :
                      image_cols_reg;
    assign rows_eff = (image_rows_reg == '0) ? ROW_W'(1) : image_rows_reg;
    assign ts_m1    = tile_side_reg - SIZE_W'(1);
    assign ts_nz    = (tile_side_reg != '0);

    assign col_ge = (col_reg >= offx_reg);
    assign row_ge = (row_reg >= ROW_W'(offy_reg));

    // grid recompute sequencer: next state
    always_comb
    begin
        calc_state_next = calc_state_reg;
        case (calc_state_reg)
            CALC_IDLE: if (geom_write) calc_state_next = CALC_COLS;
            CALC_COLS: if (div_rsp.done) calc_state_next = CALC_ROWS;
            CALC_ROWS: if (div_rsp.done) calc_state_next = CALC_CPOS;
            CALC_CPOS: if (div_rsp.done) calc_state_next = CALC_RPOS;
            CALC_RPOS: if (div_rsp.done) calc_state_next = CALC_IDLE;
            default:   calc_state_next = CALC_IDLE;
        endcase
    end

    // grid recompute sequencer: outputs
    always_comb
    begin
        div_req.start    = (calc_state_reg != CALC_IDLE) && !launched_reg;
        div_req.divisor  = tile_side_reg;
        case (calc_state_reg)
            CALC_COLS: div_req.dividend = DIV_W'(cols_eff);
            CALC_ROWS: div_req.dividend = DIV_W'(rows_eff);
            CALC_CPOS: div_req.dividend = col_ge ? DIV_W'(col_reg - offx_reg) : '0;
            CALC_RPOS: div_req.dividend = row_ge ? DIV_W'(row_reg - ROW_W'(offy_reg)) : '0;
            default:   div_req.dividend = '0;
        endcase
    end

    always_comb
    begin
        launched_next = launched_reg;
        if (div_req.start)
        begin
            launched_next = 1'b1;
        end
        else if (div_rsp.done)
        begin
            launched_next = 1'b0;
        end
    end

    // first_pixel takes this pixel back to the image origin
    always_comb
    begin
        if (in_data.first_pixel)
        begin
            cur_col    = '0;
            cur_col_in = (offx_reg == '0);
            cur_tx     = '0;
            cur_lx     = '0;
            cur_row    = '0;
            cur_row_in = (offy_reg == '0);
            cur_ty     = '0;
            cur_ly     = '0;
        end
        else
        begin
            cur_col    = col_reg;
            cur_col_in = col_in_reg;
            cur_tx     = tx_reg;
            cur_lx     = lx_reg;
            cur_row    = row_reg;
            cur_row_in = row_in_reg;
            cur_ty     = ty_reg;
            cur_ly     = ly_reg;
        end
    end

    assign lx_last = (SIZE_W'(cur_lx) == ts_m1);
    assign ly_last = (SIZE_W'(cur_ly) == ts_m1);
    assign in_grid = ts_nz && cur_col_in && (cur_tx < COL_W'(ntx_reg)) &&
                     cur_row_in && (cur_ty < nty_reg);
    assign col_p1  = {1'b0, cur_col} + (COL_W+1)'(1);
    assign row_p1  = {1'b0, cur_row} + (ROW_W+1)'(1);

    always_comb
    begin
        col_next    = col_reg;
        col_in_next = col_in_reg;
        tx_next     = tx_reg;
        lx_next     = lx_reg;
        row_next    = row_reg;
        row_in_next = row_in_reg;
        ty_next     = ty_reg;
        ly_next     = ly_reg;
        ntx_next    = ntx_reg;
        nty_next    = nty_reg;
        offx_next   = offx_reg;
        offy_next   = offy_reg;
        if (accept)
        begin
            row_next    = cur_row;
            row_in_next = cur_row_in;
            ty_next     = cur_ty;
            ly_next     = cur_ly;
            if (col_p1 >= (COL_W+1)'(cols_eff))
            begin
                col_next    = '0;
                col_in_next = (offx_reg == '0);
                tx_next     = '0;
                lx_next     = '0;
                if (row_p1 >= (ROW_W+1)'(rows_eff))
                begin
                    row_next    = '0;
                    row_in_next = (offy_reg == '0);
                    ty_next     = '0;
                    ly_next     = '0;
                end
                else
                begin
                    row_next = row_p1[ROW_W-1:0];
                    if (cur_row_in)
                    begin
                        if (ly_last)
                        begin
                            ly_next = '0;
                            ty_next = cur_ty + ROW_W'(1);
                        end
                        else
                        begin
                            ly_next = cur_ly + COL_W'(1);
                        end
                    end
                    else if (row_p1 == (ROW_W+1)'(offy_reg))
                    begin
                        row_in_next = 1'b1;
                        ty_next     = '0;
                        ly_next     = '0;
                    end
                end
            end
            else
            begin
                col_next    = col_p1[COL_W-1:0];
                col_in_next = cur_col_in;
                tx_next     = cur_tx;
                lx_next     = cur_lx;
                if (cur_col_in)
                begin
                    if (lx_last)
                    begin
                        lx_next = '0;
                        tx_next = cur_tx + COL_W'(1);
                    end
                    else
                    begin
                        lx_next = cur_lx + COL_W'(1);
                    end
                end
                else if (col_p1 == (COL_W+1)'(offx_reg))
                begin
                    col_in_next = 1'b1;
                    tx_next     = '0;
                    lx_next     = '0;
                end
            end
        end
        else if (div_rsp.done)
        begin
            case (calc_state_reg)
                CALC_COLS:
                begin
                    ntx_next  = (div_rsp.quotient > DIV_W'(MAX_TILE_COLUMNS)) ?
                                NTX_W'(MAX_TILE_COLUMNS) : div_rsp.quotient[NTX_W-1:0];
                    offx_next = COL_W'(div_rsp.remainder >> 1);
                end
                CALC_ROWS:
                begin
                    nty_next  = div_rsp.quotient;
                    offy_next = COL_W'(div_rsp.remainder >> 1);
                end
                CALC_CPOS:
                begin
                    col_in_next = col_ge;
                    tx_next     = div_rsp.quotient[COL_W-1:0];
                    lx_next     = div_rsp.remainder[COL_W-1:0];
                end
                CALC_RPOS:
                begin
                    row_in_next = row_ge;
                    ty_next     = div_rsp.quotient;
                    ly_next     = div_rsp.remainder[COL_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg <= RESET_IMAGE_ROWS;
            image_cols_reg <= RESET_IMAGE_COLS;
            tile_side_reg  <= RESET_TILE_SIZE;
            nodata_reg     <= RESET_NODATA;
            ceiling_reg    <= RESET_ELEV_CEIL;
            ntx_reg        <= '0;
            nty_reg        <= '0;
            offx_reg       <= '0;
            offy_reg       <= '0;
            col_reg        <= '0;
            col_in_reg     <= 1'b0;
            tx_reg         <= '0;
            lx_reg         <= '0;
            row_reg        <= '0;
            row_in_reg     <= 1'b0;
            ty_reg         <= '0;
            ly_reg         <= '0;
            calc_state_reg <= CALC_COLS;
            launched_reg   <= 1'b0;
        end
        else
        begin
            image_rows_reg <= image_rows_next;
            image_cols_reg <= image_cols_next;
            tile_side_reg  <= tile_side_next;
            nodata_reg     <= nodata_next;
            ceiling_reg    <= ceiling_next;
            ntx_reg        <= ntx_next;
            nty_reg        <= nty_next;
            offx_reg       <= offx_next;
            offy_reg       <= offy_next;
            col_reg        <= col_next;
            col_in_reg     <= col_in_next;
            tx_reg         <= tx_next;
            lx_reg         <= lx_next;
            row_reg        <= row_next;
            row_in_reg     <= row_in_next;
            ty_reg         <= ty_next;
            ly_reg         <= ly_next;
            calc_state_reg <= calc_state_next;
            launched_reg   <= launched_next;
        end
    end

    // margin pixels need no tile work and are dropped here
    assign op_push             = accept && in_grid;
    assign op_data.elevation   = in_data.elevation;
    assign op_data.pixel_valid = in_data.pixel_valid;
    assign op_data.tile_first  = (cur_lx == '0) && (cur_ly == '0);
    assign op_data.tile_last   = lx_last && ly_last;
    assign op_data.tile_col    = cur_tx[TILE_COL_W-1:0];
    assign op_data.row         = cur_row;
    assign op_data.col         = cur_col;

    assign thresholds.nodata  = nodata_reg;
    assign thresholds.ceiling = ceiling_reg;

endmodule

// ===== rtl/tmmf_queue.sv =====
module tmmf_queue
    import tmmf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tile_op_t      push_data,
    input  logic          pop,
    output tile_op_t      head,
    output queue_status_t status
);

    tile_op_t          entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/tmmf_back.sv =====
module tmmf_back
    import tmmf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  tile_op_t      q_head,
    input  queue_status_t q_status,
    output logic          q_pop,
    input  thresholds_t   thresholds,
    output logic          out_valid,
    input  logic          out_stall,
    output anchor_out_t   out_data
);

    // an entry that was never written reads as an empty record
    logic [MAX_TILE_COLUMNS-1:0] live_reg, live_next;

    logic        b_valid_reg, b_valid_next;
    tile_op_t    b_op_reg, b_op_next;
    logic        b_hit_reg, b_hit_next;
    tile_rec_t   b_fwd_reg, b_fwd_next;
    logic        b_live_reg, b_live_next;
    logic        out_valid_reg, out_valid_next;
    anchor_out_t out_data_reg, out_data_next;

    logic [REC_W-1:0] ram_rdata;
    logic [REC_W-1:0] ram_wdata;
    tile_rec_t        rd_rec;
    tile_rec_t        cur_rec;
    tile_rec_t        new_rec;
    logic             emit;
    logic             out_free;
    logic             b_advance;
    logic             load;

    assign rd_rec = tile_rec_t'(ram_rdata);

    always_comb
    begin
        if (b_hit_reg)
        begin
            cur_rec = b_fwd_reg;
        end
        else if (b_live_reg)
        begin
            cur_rec = rd_rec;
        end
        else
        begin
            cur_rec = '0;
        end
        new_rec = cur_rec;
        if (b_op_reg.tile_first)
        begin
            new_rec.min_elev = thresholds.ceiling;
            new_rec.found    = 1'b0;
        end
        if (b_op_reg.pixel_valid && (b_op_reg.elevation != thresholds.nodata) &&
            (b_op_reg.elevation < new_rec.min_elev))
        begin
            new_rec.min_elev = b_op_reg.elevation;
            new_rec.min_row  = b_op_reg.row;
            new_rec.min_col  = b_op_reg.col;
            new_rec.found    = 1'b1;
        end
    end

    assign emit      = b_op_reg.tile_last && new_rec.found;
    assign out_free  = !out_valid_reg || !out_stall;
    assign b_advance = b_valid_reg && (!emit || out_free);
    assign load      = !q_status.empty && (!b_valid_reg || b_advance);
    assign q_pop     = load;
    assign ram_wdata = new_rec;

    tmmf_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_TILE_COLUMNS)
    ) u_tile_ram (
        .clk   (clk),
        .we    (b_advance),
        .waddr (b_op_reg.tile_col),
        .wdata (ram_wdata),
        .re    (load),
        .raddr (q_head.tile_col),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        b_valid_next = b_valid_reg;
        b_op_next    = b_op_reg;
        b_hit_next   = b_hit_reg;
        b_fwd_next   = b_fwd_reg;
        b_live_next  = b_live_reg;
        live_next    = live_reg;
        if (b_advance)
        begin
            b_valid_next                = 1'b0;
            live_next[b_op_reg.tile_col] = 1'b1;
        end
        if (load)
        begin
            b_valid_next = 1'b1;
            b_op_next    = q_head;
            // the ram read misses a write to the same entry in this cycle
            b_hit_next   = b_advance && (b_op_reg.tile_col == q_head.tile_col);
            b_fwd_next   = new_rec;
            b_live_next  = live_reg[q_head.tile_col];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (b_advance && emit)
        begin
            out_valid_next           = 1'b1;
            out_data_next.anchor_row = new_rec.min_row;
            out_data_next.anchor_col = new_rec.min_col;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg      <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            live_reg      <= live_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_op_reg     <= b_op_next;
        b_hit_reg    <= b_hit_next;
        b_fwd_reg    <= b_fwd_next;
        b_live_reg   <= b_live_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/tmmf_checker.sv =====
`include "tiled_masked_minimum_finder_core_defines.svh"

module tmmf_checker
    import tmmf_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input anchor_out_t          out_data,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index
);

    // a stalled result stays put
    `TMMF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // a grid register write starts a recompute at once
    `TMMF_ASSERT_NXT(a_geom_recalc, cfg_valid && cfg_ready && (cfg_index == REG_IMAGE_ROWS ||
        cfg_index == REG_IMAGE_COLS || cfg_index == REG_TILE_SIZE), !cfg_ready)

    // no pixel transfer while the grid is being recomputed
    `TMMF_ASSERT_IMP(a_recalc_blocks_input, in_valid && !cfg_ready, in_stall)

    // once the recompute closes the config port, it is still closed in the next cycle
    `TMMF_ASSERT_NXT(a_recalc_length, $fell(cfg_ready), !cfg_ready)

endmodule

bind tiled_masked_minimum_finder_core tmmf_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index)
);

// ===== tb/tmmf_anchor_checker.sv =====
`timescale 1ns / 1ps

module tmmf_anchor_checker
    import tmmf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  pixel_in_t             in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  anchor_out_t           out_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    awaiting,
    output int                    anchors_checked
);

    // register copy
    logic [ROW_W-1:0]         cfg_rows;
    logic [SIZE_W-1:0]        cfg_cols;
    logic [SIZE_W-1:0]        cfg_tile;
    logic signed [ELEV_W-1:0] cfg_nodata;
    logic signed [ELEV_W-1:0] cfg_ceiling;

    // raster position of the next pixel
    int unsigned raster_row;
    int unsigned raster_col;

    // running record per tile column
    logic signed [ELEV_W-1:0] best_elev  [MAX_TILE_COLUMNS];
    logic [ROW_W-1:0]         best_row   [MAX_TILE_COLUMNS];
    logic [COL_W-1:0]         best_col   [MAX_TILE_COLUMNS];
    logic                     best_found [MAX_TILE_COLUMNS];

    anchor_out_t expected_anchors[$];
    int          error_count;
    int          match_count;

    task automatic take_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_IMAGE_ROWS: cfg_rows = value[ROW_W-1:0];
            REG_IMAGE_COLS: cfg_cols = value[SIZE_W-1:0];
            REG_TILE_SIZE:  cfg_tile = value[SIZE_W-1:0];
            REG_NODATA:     cfg_nodata = value;
            REG_ELEV_CEIL:  cfg_ceiling = value;
            default: ;
        endcase
    endtask

    task automatic track_pixel(input pixel_in_t px);
        int unsigned rows;
        int unsigned cols;
        int unsigned ts;
        int unsigned ntx;
        int unsigned nty;
        int unsigned offx;
        int unsigned offy;
        int unsigned r;
        int unsigned c;
        int unsigned tx;
        int unsigned lx;
        int unsigned ly;
        anchor_out_t anchor;
        if (px.first_pixel)
        begin
            raster_row = 0;
            raster_col = 0;
        end
        rows = (cfg_rows == 0) ? 1 : cfg_rows;
        cols = (cfg_cols == 0) ? 1 : cfg_cols;
        if (cols > MAX_COLS)
            cols = MAX_COLS;
        r = raster_row;
        c = raster_col;
        ts = cfg_tile;
        if (ts != 0)
        begin
            ntx = cols / ts;
            nty = rows / ts;
            if (ntx > MAX_TILE_COLUMNS)
                ntx = MAX_TILE_COLUMNS;
            // tile grid centred, half the remainder skipped on top and left
            offx = (cols % ts) / 2;
            offy = (rows % ts) / 2;
            if (c >= offx && c < offx + ntx * ts && r >= offy && r < offy + nty * ts)
            begin
                tx = (c - offx) / ts;
                lx = (c - offx) % ts;
                ly = (r - offy) % ts;
                if (lx == 0 && ly == 0)
                begin
                    best_elev[tx] = cfg_ceiling;
                    best_found[tx] = 1'b0;
                end
                if (px.pixel_valid && px.elevation != cfg_nodata &&
                    $signed(px.elevation) < $signed(best_elev[tx]))
                begin
                    best_elev[tx] = px.elevation;
                    best_row[tx] = r[ROW_W-1:0];
                    best_col[tx] = c[COL_W-1:0];
                    best_found[tx] = 1'b1;
                end
                if (lx == ts - 1 && ly == ts - 1 && best_found[tx])
                begin
                    anchor.anchor_row = best_row[tx];
                    anchor.anchor_col = best_col[tx];
                    expected_anchors.push_back(anchor);
                end
            end
        end
        if (c + 1 >= cols)
        begin
            raster_col = 0;
            raster_row = (r + 1 >= rows) ? 0 : r + 1;
        end
        else
        begin
            raster_col = c + 1;
        end
    endtask

    task automatic check_anchor(input anchor_out_t got);
        anchor_out_t want;
        if (expected_anchors.size() == 0)
        begin
            $display("%0t: unexpected anchor row %0d col %0d, none expected",
                     $time, got.anchor_row, got.anchor_col);
            error_count++;
        end
        else
        begin
            want = expected_anchors.pop_front();
            if (got.anchor_row !== want.anchor_row)
            begin
                $display("%0t: anchor_row mismatch: expected %0d, actual %0d",
                         $time, want.anchor_row, got.anchor_row);
                error_count++;
            end
            if (got.anchor_col !== want.anchor_col)
            begin
                $display("%0t: anchor_col mismatch: expected %0d, actual %0d",
                         $time, want.anchor_col, got.anchor_col);
                error_count++;
            end
            match_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_rows = RESET_IMAGE_ROWS;
            cfg_cols = RESET_IMAGE_COLS;
            cfg_tile = RESET_TILE_SIZE;
            cfg_nodata = RESET_NODATA;
            cfg_ceiling = RESET_ELEV_CEIL;
            raster_row = 0;
            raster_col = 0;
            for (int i = 0; i < MAX_TILE_COLUMNS; i++)
            begin
                best_elev[i] = '0;
                best_row[i] = '0;
                best_col[i] = '0;
                best_found[i] = 1'b0;
            end
            expected_anchors.delete();
            error_count = 0;
            match_count = 0;
            mismatches <= 0;
            awaiting <= 0;
            anchors_checked <= 0;
        end
        else
        begin
            // a result never leaves in the cycle of its own pixel, so compare first
            if (out_valid && !out_stall)
                check_anchor(out_data);
            if (cfg_valid && cfg_ready)
                take_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                track_pixel(in_data);
            mismatches <= error_count;
            awaiting <= expected_anchors.size();
            anchors_checked <= match_count;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tmmf_pkg::*;

    localparam logic signed [ELEV_W-1:0] ELEV_MIN = 32'sh8000_0000;
    localparam logic signed [ELEV_W-1:0] ELEV_MAX = 32'sh7FFF_FFFF;
    localparam int PHASE_PIXELS = 300;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    pixel_in_t             in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    anchor_out_t           out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int awaiting;
    int anchors_checked;

    int sender_idle_pct = 0;
    int stall_pct = 0;
    int total_pixels = 0;
    int phase_pixels = 0;
    int reg_writes = 0;

    // what the block currently holds, for sizing images and picking elevations
    logic [ROW_W-1:0]         cur_rows = RESET_IMAGE_ROWS;
    logic [SIZE_W-1:0]        cur_cols = RESET_IMAGE_COLS;
    logic signed [ELEV_W-1:0] cur_nodata = RESET_NODATA;
    logic signed [ELEV_W-1:0] cur_ceiling = RESET_ELEV_CEIL;

    always #5 clk = ~clk;

    tiled_masked_minimum_finder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tmmf_anchor_checker anchor_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .awaiting        (awaiting),
        .anchors_checked (anchors_checked)
    );

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    task automatic send_pixel(input logic signed [ELEV_W-1:0] elev, input logic vld,
                              input logic first);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{elevation: elev, pixel_valid: vld, first_pixel: first};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        total_pixels++;
        phase_pixels++;
    endtask

    // stop sending, let every anchor arrive and the pipeline empty out
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // leaves cfg_valid high so that back-to-back writes need no gap
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_IMAGE_ROWS: cur_rows = value[ROW_W-1:0];
            REG_IMAGE_COLS: cur_cols = value[SIZE_W-1:0];
            REG_NODATA:     cur_nodata = value;
            REG_ELEV_CEIL:  cur_ceiling = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    // size value, sometimes with junk above the register width
    function automatic logic [CFG_DATA_W-1:0] size_word(input int unsigned value,
                                                        input int unsigned width);
        logic [CFG_DATA_W-1:0] w;
        w = value;
        if ($urandom_range(99) < 20)
            w = w | ($urandom << width);
        return w;
    endfunction

    function automatic logic signed [ELEV_W-1:0] small_elevation();
        return int'($urandom_range(63)) - 32;
    endfunction

    function automatic logic signed [ELEV_W-1:0] random_elevation();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return cur_nodata;
        else if (sel < 13)
            return cur_ceiling;
        else if (sel < 18)
            return cur_ceiling - 1;
        else if (sel < 26)
            return $urandom;
        else if (sel < 29)
            return ELEV_MIN;
        else if (sel < 32)
            return ELEV_MAX;
        else
            return small_elevation();
    endfunction

    // fixed 4x4 picture in 2x2 tiles: ties, nodata, ceiling, masked low pixel, empty tile
    function automatic void demo_pixel(input int unsigned i, output logic signed [ELEV_W-1:0] elev,
                                       output logic vld);
        vld = 1'b1;
        case (i % 16)
            0:  elev = -5;
            1:  elev = -5;
            2:  elev = 7;
            3:  elev = 100;
            4:
            begin
                elev = ELEV_MIN;
                vld = 1'b0;
            end
            5:  elev = 0;
            6:  elev = 200;
            7:  elev = 200;
            8:  elev = ELEV_MIN;
            9:  elev = 3;
            10: elev = 50;
            11: elev = 50;
            12: elev = ELEV_MIN;
            13: elev = -1;
            14: elev = 60;
            default: elev = 49;
        endcase
    endfunction

    task automatic directed_run();
        logic signed [ELEV_W-1:0] elev;
        logic vld;
        // one-pixel tiles across an over-wide image: touches every tile column record
        // and runs past the last one
        settle();
        write_register(REG_IMAGE_ROWS, 1);
        write_register(REG_IMAGE_COLS, 16383);
        write_register(REG_TILE_SIZE, 1);
        write_register(REG_NODATA, ELEV_MIN);
        write_register(REG_ELEV_CEIL, ELEV_MAX);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 70; i++)
            send_pixel((i == 5) ? ELEV_MAX - 1 : i * 3 - 100, 1'b1, i == 0);

        settle();
        write_register(REG_IMAGE_ROWS, 4);
        write_register(REG_IMAGE_COLS, 4);
        write_register(REG_TILE_SIZE, 2);
        write_register(REG_NODATA, 7);
        write_register(REG_ELEV_CEIL, 100);
        cfg_valid <= 1'b0;
        // runs past the end of the image and wraps to the top
        for (int i = 0; i < 20; i++)
        begin
            demo_pixel(i, elev, vld);
            send_pixel(elev, vld, i == 0);
        end
        // ceiling lowered part way through the image
        settle();
        write_register(REG_ELEV_CEIL, -10);
        cfg_valid <= 1'b0;
        for (int i = 20; i < 32; i++)
        begin
            demo_pixel(i, elev, vld);
            send_pixel(elev, vld, 1'b0);
        end

        settle();
        write_register(REG_NODATA, ELEV_MAX);
        write_register(REG_ELEV_CEIL, ELEV_MIN);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 6; i++)
            send_pixel((i % 2) ? ELEV_MIN : ELEV_MAX, 1'b1, i == 0);

        settle();
        write_register(REG_IMAGE_ROWS, 65535);
        write_register(REG_TILE_SIZE, 16383);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 3; i++)
            send_pixel(ELEV_MIN + 1, 1'b1, 1'b0);

        // zero sizes behave as a single pixel image
        settle();
        write_register(REG_IMAGE_ROWS, 0);
        write_register(REG_IMAGE_COLS, 0);
        write_register(REG_TILE_SIZE, 1);
        write_register(REG_NODATA, RESET_NODATA);
        write_register(REG_ELEV_CEIL, RESET_ELEV_CEIL);
        cfg_valid <= 1'b0;
        send_pixel(5, 1'b1, 1'b1);
        send_pixel(RESET_NODATA, 1'b1, 1'b0);
        send_pixel(9, 1'b0, 1'b0);

        settle();
        write_register(REG_TILE_SIZE, 0);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 3; i++)
            send_pixel(-i, 1'b1, i == 0);

        settle();
        write_register(REG_IMAGE_ROWS, 65535);
        write_register(REG_IMAGE_COLS, 1);
        write_register(REG_TILE_SIZE, 1);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 3; i++)
            send_pixel(-7, 1'b1, i == 0);
    endtask

    task automatic random_image();
        int unsigned sel;
        int unsigned tile;
        int unsigned n_rows;
        int unsigned n_cols;
        int unsigned span;
        logic signed [ELEV_W-1:0] value;
        bit restart;
        sel = $urandom_range(99);
        tile = (sel < 8) ? 0 : (sel < 18) ? $urandom_range(6, 30) : $urandom_range(1, 5);
        n_rows = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 24);
        n_cols = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 24);

        settle();
        if ($urandom_range(99) < 80)
            write_register(REG_TILE_SIZE, size_word(tile, SIZE_W));
        if ($urandom_range(99) < 80)
            write_register(REG_IMAGE_ROWS, size_word(n_rows, ROW_W));
        if ($urandom_range(99) < 80)
            write_register(REG_IMAGE_COLS, size_word(n_cols, SIZE_W));
        if ($urandom_range(99) < 60)
        begin
            sel = $urandom_range(99);
            value = (sel < 50) ? small_elevation() : (sel < 75) ? RESET_NODATA :
                    (sel < 85) ? ELEV_MIN : (sel < 90) ? ELEV_MAX : $urandom;
            write_register(REG_NODATA, value);
        end
        if ($urandom_range(99) < 60)
        begin
            sel = $urandom_range(99);
            value = (sel < 40) ? int'($urandom_range(60)) - 20 : (sel < 70) ? RESET_ELEV_CEIL :
                    (sel < 80) ? ELEV_MIN : (sel < 90) ? ELEV_MAX : $urandom;
            write_register(REG_ELEV_CEIL, value);
        end
        cfg_valid <= 1'b0;

        n_rows = (cur_rows == 0) ? 1 : cur_rows;
        n_cols = (cur_cols == 0) ? 1 : (cur_cols > MAX_COLS) ? MAX_COLS : cur_cols;
        span = n_rows * n_cols;
        sel = $urandom_range(99);
        if (sel < 20)
            span = span + $urandom_range(1, span);
        else if (sel < 30)
            span = span / 2 + 1;
        // now and then carry on from wherever the previous image stopped
        restart = ($urandom_range(99) < 85);
        for (int unsigned i = 0; i < span; i++)
            send_pixel(random_elevation(), $urandom_range(99) < 85,
                       (i == 0 && restart) || $urandom_range(99) < 2);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        directed_run();
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 74;
                    stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct = 74;
                end
                default:
                begin
                    sender_idle_pct = 17;
                    stall_pct = 17;
                end
            endcase
            phase_pixels = 0;
            while (phase_pixels < PHASE_PIXELS)
                random_image();
        end
        settle();
        $display("run covered %0d pixel transfers, %0d anchors checked, %0d register writes",
                 total_pixels, anchors_checked, reg_writes);
        $display("over directed corner images and four idling and stall mixes");
        if (mismatches == 0 && awaiting == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tmmf_pkg.sv
rtl/tmmf_ram.sv
rtl/tmmf_div.sv
rtl/tmmf_front.sv
rtl/tmmf_queue.sv
rtl/tmmf_back.sv
rtl/tiled_masked_minimum_finder_core.sv
rtl/tmmf_checker.sv
tb/tmmf_anchor_checker.sv
tb/tb_top.sv
